// ===== design/b64e_pkg.sv =====
// Package for the base64 stream encoder: item types, queue entry type and
// the sextet-to-ASCII alphabet function. No dependencies.
`default_nettype none

package b64e_pkg;

  localparam int unsigned QueueDepthDefault = 2;
  localparam int unsigned MaxChars          = 4;
  localparam int unsigned CharW             = 7;

  localparam logic [CharW-1:0] PadChar = 7'h3d;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0] text_char;
    logic             last_char;
  } out_item_t;

  typedef enum logic [1:0] {
    GRP_FIRST  = 2'd0,
    GRP_SECOND = 2'd1,
    GRP_THIRD  = 2'd2
  } grp_pos_e;

  // One accepted byte, fully classified: characters to send and how many
  typedef struct packed {
    logic [MaxChars-1:0][CharW-1:0] chars;
    logic [1:0]                     last_idx;
    logic                           fin;
  } entry_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

  function automatic logic [CharW-1:0] sextet_char(input logic [5:0] v);
    logic [CharW-1:0] r;
    if (v < 6'd26) begin
      r = 7'd65 + {1'b0, v};
    end else if (v < 6'd52) begin
      r = 7'd71 + {1'b0, v};
    end else if (v < 6'd62) begin
      r = {1'b0, v} - 7'd4;
    end else if (v == 6'd62) begin
      r = 7'd43;
    end else begin
      r = 7'd47;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/b64e_front.sv =====
// Front end: accepts bytes, tracks group position and carried bits, and
// builds one queue entry per byte. Depends on b64e_pkg.
`default_nettype none

module b64e_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  b64e_pkg::in_item_t  in_item_i,
  input  b64e_pkg::q_status_t qstat_i,
  output logic                push_o,
  output b64e_pkg::entry_t    entry_o,
  output b64e_pkg::grp_pos_e  pos_o
);
  import b64e_pkg::*;

  grp_pos_e   pos_q, pos_d;
  logic [3:0] carry_q, carry_d;
  logic [7:0] b;

  assign in_stall_o = qstat_i.full;
  assign push_o     = in_valid_i && !qstat_i.full;
  assign pos_o      = pos_q;
  assign b          = in_item_i.data_byte;

  always_comb begin
    entry_o.chars    = '0;
    entry_o.last_idx = 2'd0;
    entry_o.fin      = in_item_i.final_byte;
    pos_d            = GRP_FIRST;
    carry_d          = 4'd0;
    unique case (pos_q)
      GRP_SECOND: begin
        entry_o.chars[0] = sextet_char({carry_q[1:0], b[7:4]});
        if (in_item_i.final_byte) begin
          entry_o.chars[1] = sextet_char({b[3:0], 2'b00});
          entry_o.chars[2] = PadChar;
          entry_o.last_idx = 2'd2;
        end else begin
          pos_d   = GRP_THIRD;
          carry_d = b[3:0];
        end
      end
      GRP_THIRD: begin
        entry_o.chars[0] = sextet_char({carry_q, b[7:6]});
        entry_o.chars[1] = sextet_char(b[5:0]);
        entry_o.last_idx = 2'd1;
      end
      default: begin
        entry_o.chars[0] = sextet_char(b[7:2]);
        if (in_item_i.final_byte) begin
          entry_o.chars[1] = sextet_char({b[1:0], 4'b0000});
          entry_o.chars[2] = PadChar;
          entry_o.chars[3] = PadChar;
          entry_o.last_idx = 2'd3;
        end else begin
          pos_d   = GRP_SECOND;
          carry_d = {2'b00, b[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= GRP_FIRST;
      carry_q <= 4'd0;
    end else if (push_o) begin
      pos_q   <= pos_d;
      carry_q <= carry_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/b64e_queue.sv =====
// Short entry queue between front and back ends.
// Depends on b64e_pkg.
`default_nettype none

module b64e_queue #(
  parameter int unsigned Depth = b64e_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  b64e_pkg::entry_t    entry_i,
  input  logic                pop_i,
  output b64e_pkg::entry_t    head_o,
  output b64e_pkg::q_status_t qstat_o
);
  import b64e_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;

  assign head_o            = mem_q[rd_ptr_q];
  assign qstat_o.not_empty = (cnt_q != '0);
  assign qstat_o.full      = (cnt_q == CntW'(Depth));

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/b64e_back.sv =====
// Back end: walks the characters of the head entry, one per cycle while the output
// is not stalled, into the output register. Depends on b64e_pkg.
`default_nettype none

module b64e_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b64e_pkg::entry_t    head_i,
  input  b64e_pkg::q_status_t qstat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output b64e_pkg::out_item_t out_item_o
);
  import b64e_pkg::*;

  logic [1:0] idx_q;
  logic       out_valid_q;
  out_item_t  out_q;
  logic       load;
  logic       at_end;

  assign load        = !out_valid_q || !out_stall_i;
  assign at_end      = (idx_q == head_i.last_idx);
  assign pop_o       = load && qstat_i.not_empty && at_end;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= qstat_i.not_empty;
      if (qstat_i.not_empty) begin
        idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && qstat_i.not_empty) begin
      out_q.text_char <= head_i.chars[idx_q];
      out_q.last_char <= head_i.fin && at_end;
    end
  end

endmodule

`default_nettype wire

// ===== design/base64_stream_encoder_core.sv =====
// Base64 stream encoder top level: front end, entry queue, back end.
// On acceptance a byte's entry is written into the queue; its first character then moves into
// the back end's output register. Throughput: one character per cycle unless the output stalls,
// set by that register; 1, 1 and 2 characters per byte of a group, up to 4 on a final byte.
// Reset clears group position, queue and output valid; no clearing pass.
// Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back.
`default_nettype none

module base64_stream_encoder_core #(
  parameter int unsigned QueueDepth = b64e_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  b64e_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output b64e_pkg::out_item_t out_item_o
);
  import b64e_pkg::*;

  q_status_t qstat;
  entry_t    entry, head;
  logic      push, pop;
  grp_pos_e  front_pos;

  b64e_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_item_i,
    .qstat_i (qstat),
    .push_o  (push),
    .entry_o (entry),
    .pos_o   (front_pos)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  b64e_back u_back (
    .clk_i,
    .rst_ni,
    .head_i  (head),
    .qstat_i (qstat),
    .pop_o   (pop),
    .out_valid_o,
    .out_stall_i,
    .out_item_o
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("queue pushed while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> qstat.not_empty)
    else $error("queue popped while empty");

  a_final_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && in_item_i.final_byte) |=> (front_pos == GRP_FIRST))
    else $error("group position not cleared after final byte");

  a_third_completes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && front_pos == GRP_THIRD) |=> (front_pos == GRP_FIRST))
    else $error("group position not cleared after third byte");

endmodule

`default_nettype wire

// ===== dv/base64_stream_encoder_core_tb.sv =====
// Testbench for base64_stream_encoder_core: a directed table of bytes, then random messages.
// Every character is checked against the table's typed text or a predictor of the padded base64 stream.
// Depends on b64e_pkg and the design files.
`default_nettype none

module base64_stream_encoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import b64e_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_BYTES = 160;
  localparam logic [6:0] EQ_PAD = 7'h3d;
  localparam logic [0:63][7:0] B64_TABLE =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // chars holds the expected text right-justified, or zero to use the predictor
  typedef struct packed {
    logic [7:0]  data;
    logic        fin;
    logic [31:0] chars;
  } dir_row_t;

  localparam int unsigned N_DIRECTED = 25;
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{8'h00, 1'b1, "AA=="}, '{8'hff, 1'b1, "/w=="},
    '{8'h00, 1'b0, "A"},    '{8'h00, 1'b0, "A"},    '{8'h00, 1'b1, "AA"},
    '{8'hff, 1'b0, "/"},    '{8'hff, 1'b0, "/"},    '{8'hff, 1'b1, "//"},
    '{8'h4d, 1'b0, "T"},    '{8'h61, 1'b0, "W"},    '{8'h6e, 1'b0, "Fu"},
    '{8'h4d, 1'b0, "T"},    '{8'h61, 1'b1, "WE="},
    '{8'hff, 1'b0, "/"},    '{8'hff, 1'b1, "/8="},
    '{8'h00, 1'b0, "A"},    '{8'h00, 1'b1, "AA="},
    '{8'hf8, 1'b0, 32'd0},  '{8'ha5, 1'b0, 32'd0},  '{8'h5a, 1'b0, 32'd0},
    '{8'h3c, 1'b0, 32'd0},  '{8'h81, 1'b1, 32'd0},
    '{8'h7e, 1'b0, 32'd0},  '{8'he7, 1'b0, 32'd0},  '{8'h18, 1'b1, 32'd0}
  };

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  // encoder state as predicted
  grp_pos_e   enc_pos = GRP_FIRST;
  logic [3:0] enc_carry = '0;

  out_item_t   expected_chars [$];
  logic [31:0] typed_q [$];
  int unsigned fail_count = 0;
  int unsigned bytes_taken = 0;
  int unsigned msgs_taken = 0;
  int unsigned chars_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          calm = 1'b1;

  base64_stream_encoder_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [6:0] b64_symbol(input logic [5:0] v);
    return B64_TABLE[v][6:0];
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // advances the predicted state; queues the characters when keep is set
  function automatic void encode_byte(input in_item_t it, input bit keep);
    out_item_t  res [4];
    int         n;
    logic [7:0] b;
    logic       fin;
    b   = it.data_byte;
    fin = it.final_byte;
    case (enc_pos)
      GRP_SECOND: begin
        res[0] = {b64_symbol({enc_carry[1:0], b[7:4]}), 1'b0};
        if (fin) begin
          res[1]    = {b64_symbol({b[3:0], 2'b00}), 1'b0};
          res[2]    = {EQ_PAD, 1'b1};
          n         = 3;
          enc_pos   = GRP_FIRST;
          enc_carry = '0;
        end else begin
          n         = 1;
          enc_pos   = GRP_THIRD;
          enc_carry = b[3:0];
        end
      end
      GRP_THIRD: begin
        res[0]    = {b64_symbol({enc_carry, b[7:6]}), 1'b0};
        res[1]    = {b64_symbol(b[5:0]), fin};
        n         = 2;
        enc_pos   = GRP_FIRST;
        enc_carry = '0;
      end
      default: begin
        res[0] = {b64_symbol(b[7:2]), 1'b0};
        if (fin) begin
          res[1]    = {b64_symbol({b[1:0], 4'b0000}), 1'b0};
          res[2]    = {EQ_PAD, 1'b0};
          res[3]    = {EQ_PAD, 1'b1};
          n         = 4;
          enc_pos   = GRP_FIRST;
          enc_carry = '0;
        end else begin
          n         = 1;
          enc_pos   = GRP_SECOND;
          enc_carry = {2'b00, b[1:0]};
        end
      end
    endcase
    if (keep) begin
      for (int k = 0; k < n; k++) expected_chars = {expected_chars, res[k]};
    end
  endfunction

  function automatic void take_byte(input in_item_t it);
    logic [31:0] typed;
    out_item_t   ch;
    typed = typed_q.pop_front();
    encode_byte(it, typed == '0);
    if (typed != '0) begin
      for (int k = 3; k >= 0; k--) begin
        if (typed[k*8 +: 8] != 8'd0) begin
          ch = {typed[k*8 +: 7], it.final_byte && (k == 0)};
          expected_chars = {expected_chars, ch};
        end
      end
    end
    bytes_taken++;
    if (it.final_byte) msgs_taken++;
  endfunction

  function automatic void check_char(input out_item_t got);
    out_item_t want;
    chars_seen++;
    if (expected_chars.size() == 0) begin
      $error("unexpected character: text_char %h last_char %b", got.text_char, got.last_char);
      fail_count++;
    end else begin
      want = expected_chars.pop_front();
      if (got.text_char !== want.text_char) begin
        $error("text_char: expected %h, got %h", want.text_char, got.text_char);
        fail_count++;
      end
      if (got.last_char !== want.last_char) begin
        $error("last_char: expected %b, got %b", want.last_char, got.last_char);
        fail_count++;
      end
    end
  endfunction

  // input side first, so a byte's characters are queued before any can be checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) take_byte(in_item_i);
      if (out_valid_o && !out_stall_i) check_char(out_item_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) stall_left = idle_len();
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters outstanding",
               cycle_count, expected_chars.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic fin, input logic [31:0] chars);
    int unsigned gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    typed_q = {typed_q, chars};
    in_valid_i <= 1'b1;
    in_item_i  <= {data, fin};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  initial begin
    int unsigned sent;
    int unsigned msg_len;
    int unsigned r;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      calm = (i < 8);
      send_byte(DIRECTED[i].data, DIRECTED[i].fin, DIRECTED[i].chars);
    end

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      r = $urandom_range(0, 9);
      if (r < 7) msg_len = $urandom_range(1, 6);
      else if (r < 9) msg_len = $urandom_range(7, 15);
      else msg_len = $urandom_range(16, 40);
      calm = ($urandom_range(0, 5) == 0);
      for (int j = 0; j < msg_len; j++) begin
        send_byte(8'($urandom_range(0, 255)), j == msg_len - 1, 32'd0);
      end
      sent += msg_len;
    end

    in_valid_i <= 1'b0;
    calm = 1'b1;
    @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("encoded %0d bytes in %0d messages; %0d characters compared",
             bytes_taken, msgs_taken, chars_seen);
    $display("stalls and gaps on both sides, %0d mismatches", fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/b64e_pkg.sv
design/b64e_front.sv
design/b64e_queue.sv
design/b64e_back.sv
design/base64_stream_encoder_core.sv
dv/base64_stream_encoder_core_tb.sv
